@@ hw/rtl/survey_polar_point_compute_unit_macros.svh @@
// assertion macros for the polar point compute unit
// used by the checker module only
`ifndef SURVEY_POLAR_POINT_COMPUTE_UNIT_MACROS_SVH
`define SURVEY_POLAR_POINT_COMPUTE_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SPP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sppc_pkg.sv @@
// shared constants, types and functions for the polar point compute unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sppc_pkg;

  localparam int CordicStages = 24;
  localparam int CordicStagesUsed = (CordicStages > 32) ? 32 : CordicStages;
  localparam int CordicW = 34;  // x/y width, 30 fractional bits
  localparam int AngW = 32;

  localparam logic [CordicW-1:0] CordicGainInv = CordicW'(652032874);

  typedef enum logic [2:0] {
    REG_STATION_EAST = 3'd0,
    REG_STATION_NORTH = 3'd1,
    REG_STATION_HEIGHT = 3'd2,
    REG_INSTRUMENT_HEIGHT = 3'd3,
    REG_ORIENTATION = 3'd4,
    REG_HEIGHT_ENABLE = 3'd5
  } cfg_reg_t;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 40;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [AngW-1:0]    z;
    logic [1:0]                quad;
  } cordic_vec_t;

  function automatic logic signed [AngW-1:0] atan_entry(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2E; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
      15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
      21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
      24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return signed'(t);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sppc_cordic.sv @@
// pipelined rotation-mode cordic: one stage per register, sin and cos out
// depends on sppc_pkg; advances when en is high
`timescale 1ns / 1ps
`default_nettype none
module sppc_cordic
  import sppc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [AngW-1:0]           angle,
  output logic signed [CordicW-1:0]      sin_o,
  output logic signed [CordicW-1:0]      cos_o
);

  cordic_vec_t stage_r [CordicStagesUsed+1];
  cordic_vec_t stage_nxt [CordicStagesUsed+1];

  always_comb begin
    stage_nxt[0].x = CordicGainInv;
    stage_nxt[0].y = '0;
    stage_nxt[0].z = signed'({2'b00, angle[AngW-3:0]});
    stage_nxt[0].quad = angle[AngW-1:AngW-2];
    for (int i = 0; i < CordicStagesUsed; i++) begin
      stage_nxt[i+1].quad = stage_r[i].quad;
      if (!stage_r[i].z[AngW-1]) begin
        stage_nxt[i+1].x = stage_r[i].x - (stage_r[i].y >>> i);
        stage_nxt[i+1].y = stage_r[i].y + (stage_r[i].x >>> i);
        stage_nxt[i+1].z = stage_r[i].z - atan_entry(i);
      end else begin
        stage_nxt[i+1].x = stage_r[i].x + (stage_r[i].y >>> i);
        stage_nxt[i+1].y = stage_r[i].y - (stage_r[i].x >>> i);
        stage_nxt[i+1].z = stage_r[i].z + atan_entry(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= CordicStagesUsed; i++) stage_r[i] <= stage_nxt[i];
    end
  end

  // quadrant fold on the last stage
  always_comb begin
    cordic_vec_t f;
    f = stage_r[CordicStagesUsed];
    unique case (f.quad)
      2'd0: begin cos_o = f.x;  sin_o = f.y;  end
      2'd1: begin cos_o = -f.y; sin_o = f.x;  end
      2'd2: begin cos_o = -f.x; sin_o = -f.y; end
      default: begin cos_o = f.y; sin_o = -f.x; end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/survey_polar_point_compute_unit.sv @@
// Polar point compute unit: from one total-station measurement (horizontal
// angle, zenith angle, slope distance, prism height) and the configured station
// it gives east, north and optionally height. Fully pipelined: one item per
// cycle while out_stall is low, through two parallel cordic pipelines
// (zenith angle and direction) followed by the multiply/round/saturate stages.
// Stall from the output freezes the whole pipeline; the output register is the
// last stage, so in_stall simply follows out_stall. Depends on sppc_pkg and
// sppc_cordic.
`timescale 1ns / 1ps
`default_nettype none
module survey_polar_point_compute_unit
  import sppc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [31:0]          in_horizontal_angle,
  input  wire logic [31:0]          in_vertical_angle,
  input  wire logic [23:0]          in_slope_distance,
  input  wire logic [15:0]          in_prism_height,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [39:0]        out_east,
  output logic signed [39:0]        out_north,
  output logic signed [25:0]        out_height,
  output logic                      out_height_valid
);

  localparam int CLat = CordicStagesUsed + 1;  // cordic register depth
  localparam int Tail = 5;                     // stages after the cordic
  localparam int Depth = CLat + Tail;
  localparam logic signed [39:0] Max40 = 40'sh7FFFFFFFFF;
  localparam logic signed [39:0] Min40 = 40'sh8000000000;
  localparam logic signed [25:0] Max26 = 26'sh1FFFFFF;
  localparam logic signed [25:0] Min26 = 26'sh2000000;

  // configuration
  logic signed [39:0] station_east_r, station_north_r;
  logic signed [23:0] station_height_r;
  logic [15:0]        instrument_height_r;
  logic [31:0]        orientation_r;
  logic               height_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_east_r <= '0;
      station_north_r <= '0;
      station_height_r <= '0;
      instrument_height_r <= '0;
      orientation_r <= '0;
      height_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STATION_EAST:      station_east_r <= signed'(cfg_data[39:0]);
        REG_STATION_NORTH:     station_north_r <= signed'(cfg_data[39:0]);
        REG_STATION_HEIGHT:    station_height_r <= signed'(cfg_data[23:0]);
        REG_INSTRUMENT_HEIGHT: instrument_height_r <= cfg_data[15:0];
        REG_ORIENTATION:       orientation_r <= cfg_data[31:0];
        REG_HEIGHT_ENABLE:     height_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together
  logic adv;
  assign adv = !out_stall;
  assign in_stall = out_stall;

  // valid bits for every stage
  logic [Depth-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[Depth-2:0], in_valid};
  end
  assign out_valid = vld_r[Depth-1];

  // direction angle wraps modulo a full turn
  logic [31:0] dir;
  assign dir = orientation_r + in_horizontal_angle;

  logic signed [CordicW-1:0] sv, cv, sh, ch;
  sppc_cordic u_cordic_v (.clk(clk), .en(adv), .angle(in_vertical_angle),
                          .sin_o(sv), .cos_o(cv));
  sppc_cordic u_cordic_h (.clk(clk), .en(adv), .angle(dir),
                          .sin_o(sh), .cos_o(ch));

  // slope distance and prism height delayed alongside the cordic
  logic [23:0] sd_dly_r [CLat];
  logic [15:0] ph_dly_r [CLat];
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_dly_r[0] <= in_slope_distance;
      ph_dly_r[0] <= in_prism_height;
      for (int i = 1; i < CLat; i++) begin
        sd_dly_r[i] <= sd_dly_r[i-1];
        ph_dly_r[i] <= ph_dly_r[i-1];
      end
    end
  end

  // t1: sd * sin(v), sd * cos(v)
  logic signed [58:0] p_sv_r, p_cv_r;
  logic signed [CordicW-1:0] sh1_r, ch1_r;
  logic [15:0] ph1_r;
  // t2: rounded hd (8 fractional bits), dz
  logic signed [36:0] hd2_r;
  logic signed [29:0] dz2_r;
  logic signed [CordicW-1:0] sh2_r, ch2_r;
  logic [15:0] ph2_r;
  // t3: hd * sin, hd * cos
  logic signed [70:0] pe3_r, pn3_r;
  logic signed [29:0] dz3_r;
  logic [15:0] ph3_r;
  // t4: rounded offsets, height sum
  logic signed [32:0] de4_r, dn4_r;
  logic signed [31:0] hs4_r;
  // t5: output register
  logic signed [39:0] east5_r, north5_r;
  logic signed [25:0] h5_r;
  logic hv5_r;

  logic signed [40:0] esum, nsum;
  logic signed [58:0] svr, cvr;
  logic signed [70:0] per, pnr;

  always_comb begin
    svr = p_sv_r + 59'sd2097152;
    cvr = p_cv_r + 59'sd536870912;
    per = pe3_r + (71'sd1 <<< 37);
    pnr = pn3_r + (71'sd1 <<< 37);
    esum = 41'(station_east_r) + 41'(de4_r);
    nsum = 41'(station_north_r) + 41'(dn4_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_sv_r <= 59'(signed'({1'b0, sd_dly_r[CLat-1]})) * 59'(sv);
      p_cv_r <= 59'(signed'({1'b0, sd_dly_r[CLat-1]})) * 59'(cv);
      sh1_r <= sh;
      ch1_r <= ch;
      ph1_r <= ph_dly_r[CLat-1];

      hd2_r <= 37'(svr >>> 22);
      dz2_r <= 30'(cvr >>> 30);
      sh2_r <= sh1_r;
      ch2_r <= ch1_r;
      ph2_r <= ph1_r;

      pe3_r <= 71'(hd2_r) * 71'(sh2_r);
      pn3_r <= 71'(hd2_r) * 71'(ch2_r);
      dz3_r <= dz2_r;
      ph3_r <= ph2_r;

      de4_r <= 33'(per >>> 38);
      dn4_r <= 33'(pnr >>> 38);
      hs4_r <= 32'(station_height_r) + 32'(signed'({1'b0, instrument_height_r}))
               + 32'(dz3_r) - 32'(signed'({1'b0, ph3_r}));

      east5_r <= (esum > 41'(Max40)) ? Max40 : ((esum < 41'(Min40)) ? Min40 : esum[39:0]);
      north5_r <= (nsum > 41'(Max40)) ? Max40 : ((nsum < 41'(Min40)) ? Min40 : nsum[39:0]);
      if (!height_enable_r) h5_r <= '0;
      else if (hs4_r > 32'(Max26)) h5_r <= Max26;
      else if (hs4_r < 32'(Min26)) h5_r <= Min26;
      else h5_r <= hs4_r[25:0];
      hv5_r <= height_enable_r;
    end
  end

  assign out_east = east5_r;
  assign out_north = north5_r;
  assign out_height = h5_r;
  assign out_height_valid = hv5_r;

endmodule
`default_nettype wire

@@ hw/rtl/sppc_checker.sv @@
// port-level checker for the polar point compute unit, bound to the top level
// depends on sppc_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "survey_polar_point_compute_unit_macros.svh"
module sppc_checker
  import sppc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic signed [39:0] out_east,
  input wire logic signed [25:0] out_height,
  input wire logic              out_height_valid
);

  `SPP_ASSERT_IMPL(a_height_zero, clk, rst_n, out_valid && !out_height_valid, out_height == '0, "height nonzero while disabled")
  `SPP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_east), "stalled item changed")
  `SPP_ASSERT_IMPL(a_stall_follow, clk, rst_n, out_stall, in_stall, "input taken while output stalled")
  `SPP_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid, "stalled input dropped")

endmodule

bind survey_polar_point_compute_unit sppc_checker u_sppc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_east(out_east),
  .out_height(out_height), .out_height_valid(out_height_valid)
);
`default_nettype wire

@@ test/tb_top.sv @@
// testbench for survey_polar_point_compute_unit: drives measurements, predicts coordinates
// with its own cordic/rounding model and checks every result in order
// depends on sppc_pkg and the unit's rtl
`timescale 1ns / 1ps
module tb_top;
  import sppc_pkg::*;

  localparam int Latency = CordicStages + 6;

  typedef struct {
    logic [31:0] hz;
    logic [31:0] zen;
    logic [23:0] sd;
    logic [15:0] ph;
  } meas_t;

  typedef struct {
    logic signed [39:0] east;
    logic signed [39:0] north;
    logic signed [25:0] height;
    logic               hvalid;
  } coord_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] in_horizontal_angle = '0;
  logic [31:0] in_vertical_angle = '0;
  logic [23:0] in_slope_distance = '0;
  logic [15:0] in_prism_height = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [39:0] out_east;
  logic signed [39:0] out_north;
  logic signed [25:0] out_height;
  logic out_height_valid;

  survey_polar_point_compute_unit dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // station setup as the predictor sees it
  logic signed [39:0] stn_e, stn_n;
  logic signed [23:0] stn_h;
  logic [15:0] inst_h;
  logic [31:0] v0;
  logic h_en;

  meas_t pending_meas[$];
  coord_t expected_coords[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int accepted = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;  // arithmetic shift is floor on signed
  endfunction

  // rotation cordic with quadrant fold, 30 fractional bits
  function automatic void sin_cos(input logic [31:0] a, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(a[29:0]);
    for (int i = 0; i < CordicStagesUsed; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_entry(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_entry(i));
      end
    end
    case (a[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic coord_t polar_to_coord(meas_t m);
    coord_t r;
    longint sv, cv, sh, ch, hd, de, dn, dz;
    logic [31:0] dir;
    dir = v0 + m.hz;
    sin_cos(m.zen, sv, cv);
    sin_cos(dir, sh, ch);
    hd = floor_shr(longint'(m.sd) * sv + (64'sd1 <<< 21), 22);
    de = floor_shr(hd * sh + (64'sd1 <<< 37), 38);
    dn = floor_shr(hd * ch + (64'sd1 <<< 37), 38);
    r.east = 40'(clamp(longint'(stn_e) + de, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1));
    r.north = 40'(clamp(longint'(stn_n) + dn, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1));
    r.height = '0;
    r.hvalid = h_en;
    if (h_en) begin
      dz = floor_shr(longint'(m.sd) * cv + (64'sd1 <<< 29), 30);
      r.height = 26'(clamp(longint'(stn_h) + longint'(inst_h) + dz - longint'(m.ph),
                           -33554432, 33554431));
    end
    return r;
  endfunction

  // register write, mirrored into the predictor (bits beyond a register dropped)
  task automatic write_reg(cfg_reg_t idx, logic [39:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_STATION_EAST: stn_e = val;
      REG_STATION_NORTH: stn_n = val;
      REG_STATION_HEIGHT: stn_h = val[23:0];
      REG_INSTRUMENT_HEIGHT: inst_h = val[15:0];
      REG_ORIENTATION: v0 = val[31:0];
      REG_HEIGHT_ENABLE: h_en = val[0];
      default: ;
    endcase
  endtask

  // index past the register list: must change nothing
  task automatic write_unused_index();
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= 3'd6 + 3'($urandom_range(0, 1));
    cfg_data <= 40'({$urandom, $urandom});
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic setup_station(logic [39:0] e, logic [39:0] n, logic [39:0] h,
                               logic [39:0] ih, logic [39:0] o, logic [39:0] en);
    write_reg(REG_STATION_EAST, e);
    write_reg(REG_STATION_NORTH, n);
    write_reg(REG_STATION_HEIGHT, h);
    write_reg(REG_INSTRUMENT_HEIGHT, ih);
    write_reg(REG_ORIENTATION, o);
    write_reg(REG_HEIGHT_ENABLE, en);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_meas.size() != 0 || expected_coords.size() != 0) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic queue_meas(logic [31:0] hz, logic [31:0] zen, logic [23:0] sd,
                            logic [15:0] ph);
    meas_t m;
    m.hz = hz; m.zen = zen; m.sd = sd; m.ph = ph;
    pending_meas.push_back(m);
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 3)) << 30;        // exact quadrant boundary
      1: return (32'($urandom_range(0, 3)) << 30) - 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random(int count);
    repeat (count) begin
      logic [23:0] sd;
      case ($urandom_range(0, 3))
        0: sd = 24'($urandom_range(0, 5000));
        1: sd = 24'hFFFFFF - 24'($urandom_range(0, 3));
        default: sd = 24'($urandom);
      endcase
      queue_meas(rand_angle(), rand_angle(), sd, 16'($urandom));
    end
  endtask

  // driver: inputs change on the falling edge, payload held while stalled
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) begin
        // hold
      end else if (pending_meas.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        meas_t m;
        m = pending_meas.pop_front();
        in_valid <= 1;
        in_horizontal_angle <= m.hz;
        in_vertical_angle <= m.zen;
        in_slope_distance <= m.sd;
        in_prism_height <= m.ph;
        expected_coords.push_back(polar_to_coord(m));
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall, with an optional long hold-off counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      coord_t exp_c;
      accepted++;
      if (expected_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result east=%0d north=%0d", out_east, out_north);
      end else begin
        exp_c = expected_coords.pop_front();
        if (out_east !== exp_c.east || out_north !== exp_c.north ||
            out_height !== exp_c.height || out_height_valid !== exp_c.hvalid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch item %0d: exp e=%0d n=%0d h=%0d hv=%0d got e=%0d n=%0d h=%0d hv=%0d",
                     accepted, exp_c.east, exp_c.north, exp_c.height, exp_c.hvalid,
                     out_east, out_north, out_height, out_height_valid);
        end
      end
    end
  end

  initial begin
    stn_e = 0; stn_n = 0; stn_h = 0; inst_h = 0; v0 = 0; h_en = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // reset state: height disabled, everything at zero
    queue_meas(32'h0, 32'h4000_0000, 24'd1000, 16'd0);
    drain();

    // directed: extremes, quadrant boundaries, height on
    setup_station(40'h0, 40'h0, 40'h00_0000_1000, 40'd1500, 40'h0, 40'd1);
    queue_meas(32'h0, 32'h0, 24'd0, 16'd0);
    queue_meas(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 16'hFFFF);
    queue_meas(32'h4000_0000, 32'h4000_0000, 24'd123456, 16'd1700);
    queue_meas(32'h8000_0000, 32'h8000_0000, 24'd10000, 16'd0);
    queue_meas(32'hC000_0000, 32'hC000_0000, 24'd10000, 16'hFFFF);
    queue_meas(32'h2000_0000, 32'h3FFF_FFFF, 24'hFFFFFF, 16'd1);
    queue_meas(32'hAAAA_AAAA, 32'h5555_5555, 24'hAAAAAA, 16'h5555);
    queue_meas(32'h5555_5555, 32'hAAAA_AAAA, 24'h555555, 16'hAAAA);
    drain();

    // saturation at the top, wrap of orientation + angle, extra data bits dropped
    write_unused_index();
    setup_station(40'h7F_FFFF_FF00, 40'h7F_FFFF_FF00, 40'hFF_7FFF_FF, 40'hFF_FFFF,
                  40'hFF_F000_0000, 40'hFF);
    queue_meas(32'h1000_0000, 32'h4000_0000, 24'hFFFFFF, 16'd0);
    queue_meas(32'h3000_0000, 32'h4000_0000, 24'hFFFFFF, 16'd0);
    queue_meas(32'hF000_0000, 32'h0, 24'hFFFFFF, 16'd0);
    queue_meas(32'h0, 32'h0, 24'hFFFFFF, 16'd0);
    drain();
    // saturation at the bottom
    setup_station(40'h80_0000_0000, 40'h80_0000_0000, 40'h80_0000, 40'd0,
                  40'hFFFF_FFFF, 40'd1);
    queue_meas(32'h8000_0000, 32'h4000_0000, 24'hFFFFFF, 16'hFFFF);
    queue_meas(32'h6000_0000, 32'h8000_0000, 24'hFFFFFF, 16'hFFFF);
    queue_meas(32'h0, 32'h0, 24'd0, 16'hFFFF);
    drain();

    // phase 1: sender idles 27, receiver 71, with a long hold-off
    send_idle_pct = 27; recv_idle_pct = 71;
    setup_station(40'({$urandom, $urandom}), 40'({$urandom, $urandom}), 40'($urandom),
                  40'($urandom), 40'($urandom), 40'd1);
    queue_random(150);
    hold_cycles = 300;
    queue_random(250);
    drain();

    // phase 2: the other way round, height off
    send_idle_pct = 71; recv_idle_pct = 27;
    setup_station(40'({$urandom, $urandom}), 40'({$urandom, $urandom}), 40'($urandom),
                  40'($urandom), 40'($urandom), 40'd0);
    queue_random(400);
    drain();

    // phase 3: no idling, small station coordinates
    send_idle_pct = 0; recv_idle_pct = 0;
    setup_station(40'($urandom_range(0, 100000)), 40'($urandom_range(0, 100000)),
                  40'($urandom), 40'($urandom), 40'($urandom), 40'd1);
    queue_random(400);
    drain();

    if (mismatches == 0 && expected_coords.size() == 0) begin
      $display("survey_polar_point_compute_unit test passed");
    end else begin
      $display("survey_polar_point_compute_unit test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("survey_polar_point_compute_unit test failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/sppc_pkg.sv
hw/rtl/sppc_cordic.sv
hw/rtl/survey_polar_point_compute_unit.sv
hw/rtl/sppc_checker.sv
test/tb_top.sv
